@@ rtl/core/bpu_pkg.sv @@
// bpu_pkg: shared types and constants for the bmp pixel unpacker
// holds mode codes, register indexes and the job record passed front to back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bpu_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int PALETTE_DEPTH     = 256;
	localparam int QUEUE_DEPTH       = 4;
	localparam int ADDR_W            = 24;
	localparam int CFG_W             = 13;
	localparam int CFG_IDX_W         = 3;
	localparam int PAL_IDX_W         = 8;
	localparam int COLOR_W           = 24;
	localparam int CNT9_W            = 9;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT = 3'd4;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [1:0] {
		MODE_PAL  = 2'd0,
		MODE_BGR  = 2'd1,
		MODE_BGRA = 2'd2,
		MODE_OFF  = 2'd3
	} pix_mode_t;

	typedef enum logic {
		KIND_PALETTE = 1'b0,
		KIND_PIXEL   = 1'b1
	} kind_t;

	typedef enum logic {
		OP_PAL_WRITE = 1'b0,
		OP_PIXEL     = 1'b1
	} op_t;

	// one queued job: palette write, or a finished pixel
	typedef struct packed {
		op_t                  op;
		logic                 use_pal;
		logic [PAL_IDX_W-1:0] index;
		logic [COLOR_W-1:0]   color;
		logic [7:0]           alpha;
		logic                 last;
	} job_t;

endpackage

`default_nettype wire

@@ rtl/core/bpu_queue.sv @@
// bpu_queue: small fifo between the front and back parts
// depends on bpu_pkg for its default depth
`timescale 1ns / 1ps
`default_nettype none

module bpu_queue
	import bpu_pkg::*;
#(
	parameter int W     = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              not_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/core/bpu_front.sv @@
// bpu_front: configuration registers, byte classification and pixel counters
// depends on bpu_pkg; feeds jobs into bpu_queue
`timescale 1ns / 1ps
`default_nettype none

module bpu_front
	import bpu_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int DIM_W         = $clog2(MAX_DIMENSION + 1),
	parameter int CNT_W         = $clog2(MAX_DIMENSION)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [7:0]           palette_index,
	input  wire logic [7:0]           entry_blue,
	input  wire logic [7:0]           entry_green,
	input  wire logic [7:0]           entry_red,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 q_full,
	output logic                      push,
	output job_t                      push_job,
	output logic [CNT_W-1:0]          push_row,
	output logic [CNT_W-1:0]          push_col,
	output logic [DIM_W-1:0]          width_eff
);

	pix_mode_t          mode_q;
	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic               half_q;
	logic [CNT9_W-1:0]  pcount_q;

	logic [1:0]         bip_q, bip_d;
	logic [CNT_W-1:0]   col_q, col_d;
	logic [CNT_W-1:0]   row_q, row_d;
	logic [1:0]         pad_q, pad_d;
	logic [COLOR_W-1:0] part_q, part_d;
	logic               done_q, done_d;

	logic               accept;
	logic               cfg_hit;
	logic               emit;
	logic               row_step;
	logic [1:0]         pad_new;
	logic [CFG_W-1:0]   height_sel;
	logic [DIM_W-1:0]   rows_eff;
	logic [CNT_W-1:0]   width_m1;
	logic [CNT_W-1:0]   rows_m1;
	logic [CNT9_W-1:0]  pal_count;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// clamp the geometry registers into the counter range
	always_comb begin
		if (width_q == '0)
			width_eff = DIM_W'(1);
		else if (32'(width_q) > 32'(MAX_DIMENSION))
			width_eff = DIM_W'(MAX_DIMENSION);
		else
			width_eff = DIM_W'(width_q);
		height_sel = half_q ? (height_q >> 1) : height_q;
		if (32'(height_sel) > 32'(MAX_DIMENSION))
			rows_eff = DIM_W'(MAX_DIMENSION);
		else
			rows_eff = DIM_W'(height_sel);
		width_m1  = CNT_W'(width_eff - DIM_W'(1));
		rows_m1   = CNT_W'(rows_eff - DIM_W'(1));
		pal_count = (pcount_q == '0 || pcount_q > CNT9_W'(PALETTE_DEPTH))
			? CNT9_W'(PALETTE_DEPTH) : pcount_q;
	end

	always_comb begin
		unique case (cfg_index)
			REG_PIXEL_MODE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
			REG_HALF_HEIGHT, REG_PALETTE_COUNT: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	// per byte counter update
	always_comb begin
		bip_d    = bip_q;
		col_d    = col_q;
		row_d    = row_q;
		pad_d    = pad_q;
		part_d   = part_q;
		done_d   = done_q;
		emit     = 1'b0;
		row_step = 1'b0;
		pad_new  = 2'd0;

		push_job.op      = OP_PIXEL;
		push_job.use_pal = 1'b0;
		push_job.index   = data_byte;
		push_job.color   = '0;
		push_job.alpha   = ALPHA_OPAQUE;
		push_job.last    = (row_q == rows_m1) && (col_q == width_m1);

		if (accept && kind == KIND_PALETTE) begin
			push_job.op    = OP_PAL_WRITE;
			push_job.index = palette_index;
			push_job.color = {entry_red, entry_green, entry_blue};
		end else if (accept && !done_q && mode_q != MODE_OFF && rows_eff != '0) begin
			if (pad_q != 2'd0) begin
				pad_d    = pad_q - 2'd1;
				row_step = (pad_q == 2'd1);
			end else begin
				unique case (mode_q)
					MODE_PAL: begin
						emit             = 1'b1;
						push_job.use_pal = ({1'b0, data_byte} < pal_count);
					end
					MODE_BGR: begin
						if (bip_q < 2'd2) begin
							part_d = part_q | (COLOR_W'(data_byte) << {bip_q, 3'b000});
							bip_d  = bip_q + 2'd1;
						end else begin
							emit           = 1'b1;
							push_job.color = {data_byte, part_q[15:0]};
							bip_d          = 2'd0;
							part_d         = '0;
						end
					end
					MODE_BGRA: begin
						if (bip_q < 2'd3) begin
							part_d = part_q | (COLOR_W'(data_byte) << {bip_q, 3'b000});
							bip_d  = bip_q + 2'd1;
						end else begin
							emit           = 1'b1;
							push_job.color = part_q;
							push_job.alpha = data_byte;
							bip_d          = 2'd0;
							part_d         = '0;
						end
					end
					MODE_OFF: begin
					end
				endcase
			end
			if (emit) begin
				if (col_q == width_m1) begin
					col_d = '0;
					// rows align to 4 bytes
					if (mode_q == MODE_PAL)
						pad_new = 2'd0 - width_eff[1:0];
					else if (mode_q == MODE_BGR)
						pad_new = width_eff[1:0];
					else
						pad_new = 2'd0;
					pad_d    = pad_new;
					row_step = (pad_new == 2'd0);
				end else begin
					col_d = col_q + CNT_W'(1);
				end
			end
		end

		if (row_step) begin
			if (row_q == rows_m1) begin
				row_d  = '0;
				done_d = 1'b1;
			end else begin
				row_d = row_q + CNT_W'(1);
			end
		end
	end

	assign push     = accept && (kind == KIND_PALETTE || emit);
	assign push_row = rows_m1 - row_q;
	assign push_col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PAL;
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
			half_q   <= 1'b0;
			pcount_q <= '0;
			bip_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			pad_q    <= '0;
			part_q   <= '0;
			done_q   <= 1'b0;
		end else if (cfg_we && cfg_hit) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:    mode_q   <= pix_mode_t'(cfg_data[1:0]);
				REG_IMAGE_WIDTH:   width_q  <= cfg_data;
				REG_IMAGE_HEIGHT:  height_q <= cfg_data;
				REG_HALF_HEIGHT:   half_q   <= cfg_data[0];
				REG_PALETTE_COUNT: pcount_q <= cfg_data[CNT9_W-1:0];
				default: begin
				end
			endcase
			bip_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pad_q  <= '0;
			part_q <= '0;
			done_q <= 1'b0;
		end else begin
			bip_q  <= bip_d;
			col_q  <= col_d;
			row_q  <= row_d;
			pad_q  <= pad_d;
			part_q <= part_d;
			done_q <= done_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/bpu_back.sv @@
// bpu_back: palette memory, address multiply and output register
// depends on bpu_pkg; drains jobs from bpu_queue
`timescale 1ns / 1ps
`default_nettype none

module bpu_back
	import bpu_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
	parameter int DIM_W         = $clog2(MAX_DIMENSION + 1),
	parameter int CNT_W         = $clog2(MAX_DIMENSION)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_not_empty,
	output logic                   pop,
	input  wire job_t              job,
	input  wire logic [CNT_W-1:0]  flip_row,
	input  wire logic [CNT_W-1:0]  column,
	input  wire logic [DIM_W-1:0]  width_eff,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [ADDR_W-1:0]      pixel_address,
	output logic [7:0]             blue,
	output logic [7:0]             green,
	output logic [7:0]             red,
	output logic [7:0]             alpha,
	output logic                   last
);

	localparam int PW = CNT_W + DIM_W;

	logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];

	logic               valid_s1;
	logic [COLOR_W-1:0] rd_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               use_pal_s1;
	logic [7:0]         alpha_s1;
	logic               last_s1;
	logic [PW-1:0]      prod_s1;
	logic [CNT_W-1:0]   col_s1;

	logic               valid_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [7:0]         alpha_s2;
	logic               last_s2;

	logic               s1_en;
	logic               s2_en;

	assign s2_en = !valid_s2 || out_ready;
	assign s1_en = !valid_s1 || s2_en;
	assign pop   = q_not_empty && s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_en)
				valid_s1 <= pop && job.op == OP_PIXEL;
			if (s2_en)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && job.op == OP_PAL_WRITE)
			pal_mem[job.index] <= job.color;
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			rd_s1      <= pal_mem[job.index];
			color_s1   <= job.color;
			use_pal_s1 <= job.use_pal;
			alpha_s1   <= job.alpha;
			last_s1    <= job.last;
			prod_s1    <= PW'(flip_row) * PW'(width_eff);
			col_s1     <= column;
		end
		if (s2_en) begin
			addr_s2  <= ADDR_W'(prod_s1) + ADDR_W'(col_s1);
			color_s2 <= use_pal_s1 ? rd_s1 : color_s1;
			alpha_s2 <= alpha_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign pixel_address = addr_s2;
	assign blue          = color_s2[7:0];
	assign green         = color_s2[15:8];
	assign red           = color_s2[23:16];
	assign alpha         = alpha_s2;
	assign last          = last_s2;

endmodule

`default_nettype wire

@@ rtl/core/bmp_pixel_unpacker_core.sv @@
// channel   | handshake             | payload
// input     | in_valid / in_ready   | kind, palette_index, entry_blue/green/red, data_byte
// output    | out_valid / out_ready | pixel_address, blue, green, red, alpha, last
// config    | cfg_we (no wait)      | cfg_index, cfg_data
//
// one input transaction per clock sustained while out_ready holds,
// palette loads and padding bytes included
// a pixel passes through the queue slot, written at the edge that takes its last byte,
// then the palette read / address multiply stage and the output stage, which drives out_valid
// reset clears the counters, queue and pipeline valids; the palette memory is not cleared
// output stalls fill the four-entry queue before in_ready drops
// top level: bmp pixel unpacker, wires front, queue and back together
// depends on bpu_pkg, bpu_front, bpu_queue, bpu_back
`timescale 1ns / 1ps
`default_nettype none

module bmp_pixel_unpacker_core
	import bpu_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration writes
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input transactions
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 kind,
	input  wire logic [7:0]           palette_index,
	input  wire logic [7:0]           entry_blue,
	input  wire logic [7:0]           entry_green,
	input  wire logic [7:0]           entry_red,
	input  wire logic [7:0]           data_byte,
	// output transactions
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [ADDR_W-1:0]         pixel_address,
	output logic [7:0]                blue,
	output logic [7:0]                green,
	output logic [7:0]                red,
	output logic [7:0]                alpha,
	output logic                      last
);

	// width of the clamped dimensions and of the row / column counters
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int QW    = $bits(job_t) + 2 * CNT_W;

	logic             q_full;
	logic             q_not_empty;
	logic             push;
	logic             pop;
	job_t             push_job;
	job_t             pop_job;
	logic [CNT_W-1:0] push_row;
	logic [CNT_W-1:0] push_col;
	logic [CNT_W-1:0] pop_row;
	logic [CNT_W-1:0] pop_col;
	logic [DIM_W-1:0] width_eff;
	logic [QW-1:0]    q_in;
	logic [QW-1:0]    q_out;

	// front: config registers, byte classification, row / column / padding counters
	bpu_front #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.DIM_W         (DIM_W),
		.CNT_W         (CNT_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.palette_index (palette_index),
		.entry_blue    (entry_blue),
		.entry_green   (entry_green),
		.entry_red     (entry_red),
		.data_byte     (data_byte),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job),
		.push_row      (push_row),
		.push_col      (push_col),
		.width_eff     (width_eff)
	);

	// palette writes and pixels share the queue so their order is kept
	assign q_in                       = {push_job, push_row, push_col};
	assign {pop_job, pop_row, pop_col} = q_out;

	bpu_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_out),
		.not_empty (q_not_empty)
	);

	// back: palette memory, row flip address, output register
	bpu_back #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.DIM_W         (DIM_W),
		.CNT_W         (CNT_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.pop           (pop),
		.job           (pop_job),
		.flip_row      (pop_row),
		.column        (pop_col),
		.width_eff     (width_eff),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.blue          (blue),
		.green         (green),
		.red           (red),
		.alpha         (alpha),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ rtl/core/bpu_checker.sv @@
// bpu_checker: port level assertions for bmp_pixel_unpacker_core, with its bind
// depends on bpu_pkg; tracks the mode and width registers from the config port
`timescale 1ns / 1ps
`default_nettype none

module bpu_checker
	import bpu_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0]     cfg_data,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [ADDR_W-1:0]    pixel_address,
	input wire logic [7:0]           blue,
	input wire logic [7:0]           green,
	input wire logic [7:0]           red,
	input wire logic [7:0]           alpha,
	input wire logic                 last
);

	logic [1:0]       mode_q;
	logic [CFG_W-1:0] width_q;
	logic [31:0]      width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PAL;
			width_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_PIXEL_MODE)
				mode_q <= cfg_data[1:0];
			if (cfg_index == REG_IMAGE_WIDTH)
				width_q <= cfg_data;
		end
	end

	always_comb begin
		if (width_q == '0)
			width_eff = 32'd1;
		else if (32'(width_q) > 32'(MAX_DIMENSION))
			width_eff = 32'(MAX_DIMENSION);
		else
			width_eff = 32'(width_q);
	end

	// nothing comes out right after reset
	a_quiet_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output transaction right after reset");

	// a stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_address)
			&& $stable(blue) && $stable(green) && $stable(red)
			&& $stable(alpha) && $stable(last))
		else $error("stalled output transaction changed");

	// alpha is only copied in 32-bit mode
	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q != MODE_BGRA |-> alpha == ALPHA_OPAQUE)
		else $error("alpha not opaque outside 32-bit mode");

	// the final pixel lands at the end of the top output row
	a_last_address: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> pixel_address == ADDR_W'(width_eff - 32'd1))
		else $error("last pixel at wrong address");

endmodule

bind bmp_pixel_unpacker_core bpu_checker #(
	.MAX_DIMENSION (MAX_DIMENSION)
) u_bpu_checker (.*);

`default_nettype wire
